>>> design/bsq_pkg.sv
// Shared constants and types for the button and slider qualifier.
package bsq_pkg;

  // Button lanes handled at most, and the slider's event source code
  localparam int MaxButtons = 8;
  localparam int EventSlots = MaxButtons + 1;
  localparam int DefaultButtonCount = 8;
  localparam int KillButton = 0;
  localparam int ToggleButton = 4;

  // Field widths
  localparam int TimerWidth = 16;
  localparam int SampleWidth = 10;
  localparam int SourceWidth = 4;
  localparam int ValueWidth = 3;
  localparam int BandWidth = 3;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [SourceWidth-1:0] SliderSource = 4'd8;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] RegButtonDebounce = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegSliderSettle = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegBandEdgeOne = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegBandEdgeTwo = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegBandEdgeThree = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegBandEdgeFour = 3'd5;

  // Reset values of the registers
  localparam logic [TimerWidth-1:0] DebounceReset = 16'd10;
  localparam logic [TimerWidth-1:0] SettleReset = 16'd10;
  localparam logic [SampleWidth-1:0] EdgeOneReset = 10'd695;
  localparam logic [SampleWidth-1:0] EdgeTwoReset = 10'd570;
  localparam logic [SampleWidth-1:0] EdgeThreeReset = 10'd407;
  localparam logic [SampleWidth-1:0] EdgeFourReset = 10'd293;

  // Bands
  localparam logic [BandWidth-1:0] BandNone = 3'd0;
  localparam logic [BandWidth-1:0] BandOne = 3'd1;
  localparam logic [BandWidth-1:0] BandTwo = 3'd2;
  localparam logic [BandWidth-1:0] BandThree = 3'd3;
  localparam logic [BandWidth-1:0] BandFour = 3'd4;
  localparam logic [BandWidth-1:0] BandFive = 3'd5;

  // Event found by one button lane during a tick
  typedef struct packed {
    logic fire;
    logic value;
  } lane_event_t;

  // Event found by the slider unit during a tick
  typedef struct packed {
    logic fire;
    logic [BandWidth-1:0] band;
  } slider_event_t;

  // Saturating tick counter step
  function automatic logic [TimerWidth-1:0] timer_inc(input logic [TimerWidth-1:0] t);
    timer_inc = (t == {TimerWidth{1'b1}}) ? t : t + TimerWidth'(1);
  endfunction

endpackage

>>> design/bsq_lane.sv
// One debounce lane: stable-interval filter and edge event for a single button.
module bsq_lane #(
  parameter bit ACTIVE_HIGH = 1'b0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             raw,
  input  logic [bsq_pkg::TimerWidth-1:0]   debounce,
  output bsq_pkg::lane_event_t             event_out
);
  import bsq_pkg::*;

  logic                  raw_previous;
  logic                  stable_level;
  logic [TimerWidth-1:0] hold_timer;
  logic [TimerWidth-1:0] hold_timer_next;
  logic [TimerWidth-1:0] timer_step;
  logic                  fire;

  // Hold timer restarts on any raw change, level is taken once held long enough
  always_comb begin
    timer_step = timer_inc(hold_timer);
    fire = 1'b0;
    if (raw != raw_previous) begin
      hold_timer_next = '0;
    end else if (timer_step >= debounce && raw != stable_level) begin
      hold_timer_next = '0;
      fire = 1'b1;
    end else begin
      hold_timer_next = timer_step;
    end
  end

  assign event_out.fire = accept & fire;
  // Pull-up inputs: active-low buttons press on a falling edge
  assign event_out.value = ACTIVE_HIGH ? raw : ~raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous <= 1'b1;
      stable_level <= 1'b1;
      hold_timer <= '0;
    end else if (accept) begin
      raw_previous <= raw;
      hold_timer <= hold_timer_next;
      if (fire) begin
        stable_level <= raw;
      end
    end
  end

endmodule

>>> design/bsq_slider.sv
// Slider banding against four thresholds with settle timer and change report.
module bsq_slider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [bsq_pkg::SampleWidth-1:0] sample,
  input  logic [bsq_pkg::TimerWidth-1:0]  settle,
  input  logic [bsq_pkg::SampleWidth-1:0] edge_one,
  input  logic [bsq_pkg::SampleWidth-1:0] edge_two,
  input  logic [bsq_pkg::SampleWidth-1:0] edge_three,
  input  logic [bsq_pkg::SampleWidth-1:0] edge_four,
  output bsq_pkg::slider_event_t          event_out
);
  import bsq_pkg::*;

  logic [BandWidth-1:0]  band;
  logic [BandWidth-1:0]  slider_pending;
  logic [BandWidth-1:0]  slider_sent;
  logic [TimerWidth-1:0] slider_timer;
  logic [TimerWidth-1:0] slider_timer_next;
  logic                  report;

  // First threshold exceeded decides the band
  always_comb begin
    if (sample > edge_one) begin
      band = BandOne;
    end else if (sample > edge_two) begin
      band = BandTwo;
    end else if (sample > edge_three) begin
      band = BandThree;
    end else if (sample > edge_four) begin
      band = BandFour;
    end else begin
      band = BandFive;
    end
  end

  // Settle timer and report decision
  always_comb begin
    slider_timer_next = (band != slider_pending) ? '0 : timer_inc(slider_timer);
    report = (slider_timer_next > settle) && (band != slider_sent);
  end

  assign event_out.fire = accept & report;
  assign event_out.band = band;

  always_ff @(posedge clk) begin
    if (rst) begin
      slider_pending <= BandNone;
      slider_sent <= BandNone;
      slider_timer <= '0;
    end else if (accept) begin
      slider_pending <= band;
      slider_timer <= slider_timer_next;
      if (report) begin
        slider_sent <= band;
      end
    end
  end

endmodule

>>> design/bsq_merge.sv
// Merge stage: holds one tick's events and sends them out one per transaction.
module bsq_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  output logic                                 take_ready,
  input  bsq_pkg::lane_event_t [bsq_pkg::MaxButtons-1:0] button_events,
  input  bsq_pkg::slider_event_t               slider_event,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bsq_pkg::SourceWidth-1:0]      out_source,
  output logic [bsq_pkg::ValueWidth-1:0]       out_value,
  output logic                                 out_last
);
  import bsq_pkg::*;

  localparam int LevelIndexWidth = $clog2(MaxButtons);

  logic                  batch_valid;
  logic [EventSlots-1:0] batch_mask;
  logic [MaxButtons-1:0] batch_level;
  logic [BandWidth-1:0]  batch_band;

  logic [EventSlots-1:0] new_mask;
  logic [MaxButtons-1:0] new_level;
  logic [SourceWidth-1:0] pick;
  logic [EventSlots-1:0] remaining;
  logic                  send;
  logic                  load;

  // Gather this tick's events
  always_comb begin
    for (int k = 0; k < MaxButtons; k++) begin
      new_mask[k] = button_events[k].fire;
      new_level[k] = button_events[k].value;
    end
    new_mask[EventSlots-1] = slider_event.fire;
  end

  // Lowest pending source goes first
  always_comb begin
    pick = '0;
    for (int k = EventSlots - 1; k >= 0; k--) begin
      if (batch_mask[k]) begin
        pick = SourceWidth'(k);
      end
    end
    remaining = batch_mask & ~(EventSlots'(1) << pick);
  end

  assign send = batch_valid && (!out_valid || out_ready);
  assign load = accept && (new_mask != '0);
  assign take_ready = !batch_valid || (send && remaining == '0);

  // Batch control
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_valid <= 1'b0;
    end else if (load) begin
      batch_valid <= 1'b1;
    end else if (send && remaining == '0) begin
      batch_valid <= 1'b0;
    end
  end

  // Batch payload
  always_ff @(posedge clk) begin
    if (load) begin
      batch_mask <= new_mask;
      batch_level <= new_level;
      batch_band <= slider_event.band;
    end else if (send) begin
      batch_mask <= remaining;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_source <= pick;
      out_last <= (remaining == '0);
      if (pick == SliderSource) begin
        out_value <= batch_band;
      end else begin
        out_value <= ValueWidth'(batch_level[pick[LevelIndexWidth-1:0]]);
      end
    end
  end

endmodule

>>> design/button_and_slider_qualifier.sv
// Top level of the button and slider qualifier.
// Usage: one input transaction per millisecond tick on s_tdata carries the raw
// pull-up button levels and one slider ADC sample. Each button runs in its own
// debounce lane; the slider unit bands the sample and applies the settle time.
// Every qualified change leaves as one output transaction on m_tdata (source,
// value), buttons in index order, then the slider; m_tlast marks the tick's
// final event. A tick with no qualified change produces no output.
// Path: an accepted tick's events pass through the event buffer and then the
// output register before they show on m_tvalid. While m_tready does not stall
// it, the output register sends one event per cycle; s_tready is high again in
// the cycle a tick's last event moves to the output register. Ticks with at
// most one event are taken back to back, one per cycle, while the output is
// not stalled.
// Stalls: when m_tready is low the output register and event buffer hold, and
// s_tready drops once the buffer is occupied. Configuration writes on cfg_we
// take effect at once and are meant for idle periods.
// Reset (rst, synchronous): registers return to their defaults, every lane's level
// reads high (released for active-low buttons), no slider band is pending or sent, output is empty.
module button_and_slider_qualifier #(
  parameter int BUTTON_COUNT = bsq_pkg::DefaultButtonCount
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] button_levels, [17:8] slider_sample, [23:18] zero
  input  logic [23:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] event_source, [6:4] event_value, [7] zero
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [bsq_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bsq_pkg::CfgDataWidth-1:0]  cfg_data
);
  import bsq_pkg::*;

  localparam int LaneCount = (BUTTON_COUNT < MaxButtons) ? BUTTON_COUNT : MaxButtons;

  logic [TimerWidth-1:0]  button_debounce_ms;
  logic [TimerWidth-1:0]  slider_settle_ms;
  logic [SampleWidth-1:0] band_edge_one;
  logic [SampleWidth-1:0] band_edge_two;
  logic [SampleWidth-1:0] band_edge_three;
  logic [SampleWidth-1:0] band_edge_four;

  logic                    accept;
  logic [MaxButtons-1:0]   button_levels;
  logic [SampleWidth-1:0]  slider_sample;
  lane_event_t [MaxButtons-1:0] button_events;
  slider_event_t           slider_event;
  logic [SourceWidth-1:0]  event_source;
  logic [ValueWidth-1:0]   event_value;

  assign accept = s_tvalid & s_tready;
  assign button_levels = s_tdata[MaxButtons-1:0];
  assign slider_sample = s_tdata[MaxButtons +: SampleWidth];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      button_debounce_ms <= DebounceReset;
      slider_settle_ms <= SettleReset;
      band_edge_one <= EdgeOneReset;
      band_edge_two <= EdgeTwoReset;
      band_edge_three <= EdgeThreeReset;
      band_edge_four <= EdgeFourReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegButtonDebounce: button_debounce_ms <= cfg_data;
        RegSliderSettle:   slider_settle_ms <= cfg_data;
        RegBandEdgeOne:    band_edge_one <= cfg_data[SampleWidth-1:0];
        RegBandEdgeTwo:    band_edge_two <= cfg_data[SampleWidth-1:0];
        RegBandEdgeThree:  band_edge_three <= cfg_data[SampleWidth-1:0];
        RegBandEdgeFour:   band_edge_four <= cfg_data[SampleWidth-1:0];
        default: ;
      endcase
    end
  end

  // Debounce lanes; kill switch and toggle report the raw level directly
  genvar g;
  generate
    for (g = 0; g < MaxButtons; g++) begin : g_lane
      if (g < LaneCount) begin : g_used
        bsq_lane #(
          .ACTIVE_HIGH((g == KillButton) || (g == ToggleButton))
        ) u_lane (
          .clk       (clk),
          .rst       (rst),
          .accept    (accept),
          .raw       (button_levels[g]),
          .debounce  (button_debounce_ms),
          .event_out (button_events[g])
        );
      end else begin : g_unused
        assign button_events[g] = '0;
      end
    end
  endgenerate

  bsq_slider u_slider (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (slider_sample),
    .settle     (slider_settle_ms),
    .edge_one   (band_edge_one),
    .edge_two   (band_edge_two),
    .edge_three (band_edge_three),
    .edge_four  (band_edge_four),
    .event_out  (slider_event)
  );

  bsq_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .take_ready    (s_tready),
    .button_events (button_events),
    .slider_event  (slider_event),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_source    (event_source),
    .out_value     (event_value),
    .out_last      (m_tlast)
  );

  assign m_tdata = {1'b0, event_value, event_source};

endmodule

>>> tb/button_and_slider_qualifier_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the qualifier's events per tick and compares them with the output stream.
module button_and_slider_qualifier_checker #(
  parameter int BUTTON_COUNT = bsq_pkg::DefaultButtonCount
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // [7:0] button_levels, [17:8] slider_sample, [23:18] zero
  input  logic [23:0]                       s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] event_source, [6:4] event_value, [7] zero
  input  logic [7:0]                        m_tdata,
  input  logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [bsq_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bsq_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                fail_count,
  output int                                pending_events
);
  import bsq_pkg::*;

  localparam int LaneCount = (BUTTON_COUNT < MaxButtons) ? BUTTON_COUNT : MaxButtons;

  typedef struct packed {
    logic [SourceWidth-1:0] source;
    logic [ValueWidth-1:0]  value;
    logic                   last;
  } qual_event_t;

  // Register copy
  logic [TimerWidth-1:0]  debounce_ms;
  logic [TimerWidth-1:0]  settle_ms;
  logic [SampleWidth-1:0] edge_one;
  logic [SampleWidth-1:0] edge_two;
  logic [SampleWidth-1:0] edge_three;
  logic [SampleWidth-1:0] edge_four;

  // Debounce and slider state copy
  logic [MaxButtons-1:0]  raw_seen;
  logic [MaxButtons-1:0]  stable_level;
  logic [TimerWidth-1:0]  hold_ms [MaxButtons];
  logic [BandWidth-1:0]   band_pending;
  logic [BandWidth-1:0]   band_sent;
  logic [TimerWidth-1:0]  band_held_ms;

  // Events predicted but not yet seen on the output
  qual_event_t expected_events[$];

  // First edge the sample exceeds decides the band, edges tested in order
  function automatic logic [BandWidth-1:0] band_for(input logic [SampleWidth-1:0] sample);
    if (sample > edge_one) return BandOne;
    if (sample > edge_two) return BandTwo;
    if (sample > edge_three) return BandThree;
    if (sample > edge_four) return BandFour;
    return BandFive;
  endfunction

  task automatic clear_model();
    int b;
    debounce_ms = DebounceReset;
    settle_ms = SettleReset;
    edge_one = EdgeOneReset;
    edge_two = EdgeTwoReset;
    edge_three = EdgeThreeReset;
    edge_four = EdgeFourReset;
    raw_seen = '1;
    stable_level = '1;
    for (b = 0; b < MaxButtons; b++) hold_ms[b] = '0;
    band_pending = BandNone;
    band_sent = BandNone;
    band_held_ms = '0;
    expected_events.delete();
    fail_count = 0;
  endtask

  // One millisecond tick: debounce every lane, then band and settle the slider
  task automatic qualify_tick(input logic [MaxButtons-1:0] levels,
                              input logic [SampleWidth-1:0] sample);
    qual_event_t found[$];
    qual_event_t ev;
    logic [BandWidth-1:0] band;
    int b;
    for (b = 0; b < LaneCount; b++) begin
      if (levels[b] != raw_seen[b]) begin
        raw_seen[b] = levels[b];
        hold_ms[b] = '0;
      end else begin
        if (hold_ms[b] != '1) hold_ms[b] = hold_ms[b] + 1'b1;
        if (hold_ms[b] >= debounce_ms && levels[b] != stable_level[b]) begin
          stable_level[b] = levels[b];
          hold_ms[b] = '0;
          ev.source = SourceWidth'(b);
          // kill switch and toggle report the level; the rest are active low
          if (b == KillButton || b == ToggleButton) ev.value = ValueWidth'(levels[b]);
          else ev.value = ValueWidth'(!levels[b]);
          ev.last = 1'b0;
          found.push_back(ev);
        end
      end
    end
    band = band_for(sample);
    if (band != band_pending) begin
      band_pending = band;
      band_held_ms = '0;
    end else if (band_held_ms != '1) begin
      band_held_ms = band_held_ms + 1'b1;
    end
    if (band_held_ms > settle_ms && band_pending != band_sent) begin
      band_sent = band_pending;
      ev.source = SliderSource;
      ev.value = band_sent;
      ev.last = 1'b0;
      found.push_back(ev);
    end
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    foreach (found[k]) expected_events.push_back(found[k]);
  endtask

  // Watch configuration, input and output transactions on each rising edge
  always @(posedge clk) begin : watch
    qual_event_t want;
    logic [SourceWidth-1:0] got_source;
    logic [ValueWidth-1:0] got_value;
    if (rst) begin
      clear_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegButtonDebounce: debounce_ms = cfg_data;
          RegSliderSettle:   settle_ms = cfg_data;
          RegBandEdgeOne:    edge_one = cfg_data[SampleWidth-1:0];
          RegBandEdgeTwo:    edge_two = cfg_data[SampleWidth-1:0];
          RegBandEdgeThree:  edge_three = cfg_data[SampleWidth-1:0];
          RegBandEdgeFour:   edge_four = cfg_data[SampleWidth-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        qualify_tick(s_tdata[MaxButtons-1:0], s_tdata[8 +: SampleWidth]);
      end
      if (m_tvalid && m_tready) begin
        got_source = m_tdata[3:0];
        got_value = m_tdata[6:4];
        if (expected_events.size() == 0) begin
          $error("event with none expected: event_source %0d event_value %0d last_event %0d",
                 got_source, got_value, m_tlast);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (got_source !== want.source) begin
            $error("event_source: expected %0d, actual %0d", want.source, got_source);
            fail_count++;
          end
          if (got_value !== want.value) begin
            $error("event_value: expected %0d, actual %0d", want.value, got_value);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_event: expected %0d, actual %0d", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending_events = expected_events.size();
  end

endmodule

>>> tb/button_and_slider_qualifier_test.sv
`timescale 1ns / 1ps
// Testbench top for the button and slider qualifier: tick stimulus, configuration and verdict.
module button_and_slider_qualifier_test;
  import bsq_pkg::*;

  localparam int ResetCycles = 12;
  localparam int PhaseTicks = 80;
  localparam int RandomPhases = 5;
  localparam int HoldOffCycles = 400;
  localparam int SettleCycles = 8;
  localparam int LongHoldTicks = 20;
  localparam int CycleLimit = 800000;
  localparam logic [CfgIndexWidth-1:0] RegSpareLow = 3'd6;
  localparam logic [CfgIndexWidth-1:0] RegSpareHigh = 3'd7;
  localparam logic [TimerWidth-1:0] TimerTop = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  int fail_count;
  int pending_events;

  // Stimulus control shared with the receiver process
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;

  // What the stimulus last held and last wrote
  logic [7:0] held_levels = 8'hFF;
  logic [TimerWidth-1:0] debounce_now = DebounceReset;
  logic [TimerWidth-1:0] settle_now = SettleReset;
  logic [SampleWidth-1:0] band_edges [4] = '{EdgeOneReset, EdgeTwoReset,
                                            EdgeThreeReset, EdgeFourReset};

  button_and_slider_qualifier u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  button_and_slider_qualifier_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_events(pending_events)
  );

  always #1 clk = ~clk;

  // Timeout
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One tick transaction, with an optional idle burst ahead of it
  task automatic send_tick(input logic [7:0] levels, input logic [SampleWidth-1:0] sample);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, sample, levels};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic hold_ticks(input logic [7:0] levels, input logic [SampleWidth-1:0] sample,
                            input int count);
    int k;
    for (k = 0; k < count; k++) send_tick(levels, sample);
    held_levels = levels;
  endtask

  // Write one register, dropping cfg_we again before returning so it falls between writes
  task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                           input logic [CfgDataWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (index)
      RegButtonDebounce: debounce_now = value;
      RegSliderSettle:   settle_now = value;
      RegBandEdgeOne:    band_edges[0] = value[SampleWidth-1:0];
      RegBandEdgeTwo:    band_edges[1] = value[SampleWidth-1:0];
      RegBandEdgeThree:  band_edges[2] = value[SampleWidth-1:0];
      RegBandEdgeFour:   band_edges[3] = value[SampleWidth-1:0];
      default: ;
    endcase
  endtask

  // pad fills the unused upper bits of the write data
  task automatic set_edges(input logic [5:0] pad, input logic [SampleWidth-1:0] e1,
                           input logic [SampleWidth-1:0] e2, input logic [SampleWidth-1:0] e3,
                           input logic [SampleWidth-1:0] e4);
    write_reg(RegBandEdgeOne, {pad, e1});
    write_reg(RegBandEdgeTwo, {pad, e2});
    write_reg(RegBandEdgeThree, {pad, e3});
    write_reg(RegBandEdgeFour, {pad, e4});
  endtask

  // Stop sending, wait for every expected event, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_events != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Half the samples sit on or just above a band edge to hit the comparisons; the rest are random
  function automatic logic [SampleWidth-1:0] pick_sample();
    logic [SampleWidth-1:0] near;
    near = band_edges[$urandom_range(0, 3)];
    case ($urandom_range(0, 3))
      0: return near;
      1: return near + 1'b1;
      default: return SampleWidth'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [7:0] flip_mask();
    if ($urandom_range(0, 2) == 0) return 8'($urandom());
    return 8'(1 << $urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    int phase;
    int ticks;
    int span;
    int longest;
    logic [7:0] levels;
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: all buttons fall together, slider settles in band one
    hold_ticks(8'h00, 10'd1023, 12);
    drain();

    // Zero debounce and zero settle; spare register indexes are ignored
    write_reg(RegButtonDebounce, 16'd0);
    write_reg(RegSliderSettle, 16'd0);
    write_reg(RegSpareLow, 16'hFFFF);
    write_reg(RegSpareHigh, 16'h0001);
    hold_ticks(8'hFF, 10'd0, 2);
    hold_ticks(8'hAA, 10'd695, 2);
    hold_ticks(8'h55, 10'd696, 2);
    hold_ticks(8'h55, 10'd293, 2);
    // one-tick glitch on the kill switch is filtered
    send_tick(8'h54, 10'd407);
    hold_ticks(8'h55, 10'd408, 2);
    drain();

    // Band edges out of order
    set_edges(6'd0, 10'd100, 10'd900, 10'd50, 10'd1023);
    hold_ticks(8'h55, 10'd500, 2);
    hold_ticks(8'h55, 10'd60, 2);
    hold_ticks(8'h55, 10'd20, 2);
    drain();

    // Largest debounce and settle: nothing qualifies during a long hold
    write_reg(RegButtonDebounce, TimerTop);
    write_reg(RegSliderSettle, TimerTop);
    quiet = 1'b1;
    hold_ticks(~held_levels, 10'd500, LongHoldTicks);
    quiet = 1'b0;
    drain();

    // Random phases, each with its own settings
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin
          write_reg(RegButtonDebounce, 16'($urandom_range(0, 3)));
          write_reg(RegSliderSettle, 16'($urandom_range(0, 3)));
          set_edges(6'd0, 10'($urandom_range(700, 1000)), 10'($urandom_range(500, 699)),
                    10'($urandom_range(300, 499)), 10'($urandom_range(50, 299)));
        end
        1: begin
          write_reg(RegButtonDebounce, 16'd1);
          write_reg(RegSliderSettle, 16'd0);
          set_edges(6'h3F, 10'($urandom_range(700, 1000)), 10'($urandom_range(500, 699)),
                    10'($urandom_range(300, 499)), 10'($urandom_range(50, 299)));
        end
        2: begin
          write_reg(RegButtonDebounce, 16'($urandom_range(0, 4)));
          write_reg(RegSliderSettle, 16'($urandom_range(0, 4)));
          set_edges(6'd0, 10'd1023, 10'd1023, 10'd0, 10'd0);
        end
        3: begin
          write_reg(RegButtonDebounce, 16'd0);
          write_reg(RegSliderSettle, 16'($urandom_range(0, 2)));
          set_edges(6'd0, 10'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()));
        end
        default: begin
          // debounce one above settle lines button and slider events up on one tick
          write_reg(RegButtonDebounce, 16'd2);
          write_reg(RegSliderSettle, 16'd1);
          set_edges(6'd0, EdgeOneReset, EdgeTwoReset, EdgeThreeReset, EdgeFourReset);
        end
      endcase
      if (phase == 0) hold_off_req = 1'b1;

      longest = (debounce_now > settle_now) ? debounce_now : settle_now;
      ticks = 0;
      while (ticks < PhaseTicks) begin
        if (phase == RandomPhases - 1 && ticks >= PhaseTicks / 2) quiet = 1'b1;
        if ($urandom_range(0, 9) < 7) begin
          // deliberate change, held long enough to qualify or short of it
          levels = held_levels ^ flip_mask();
          span = $urandom_range(1, longest + 3);
          hold_ticks(levels, pick_sample(), span);
          ticks += span;
        end else begin
          // bounce noise
          send_tick(8'($urandom()), SampleWidth'($urandom()));
          ticks++;
        end
      end
      drain();
    end

    if (pending_events != 0) $error("%0d expected events never arrived", pending_events);
    if (fail_count == 0 && pending_events == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
